@@ hdl/synced_joint_motion_profiler_defines.svh @@
// Assertion macros for the synced joint motion profiler.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef SYNCED_JOINT_MOTION_PROFILER_DEFINES_SVH
`define SYNCED_JOINT_MOTION_PROFILER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SJMP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SJMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sjmp_pkg.sv @@
// Shared types and constants of the synced joint motion profiler.
// No dependencies; imported by every module of the block.
package sjmp_pkg;

  localparam int unsigned NJ       = 5;
  localparam int unsigned ANG_W    = 17;
  localparam int unsigned TDATA_W  = 88;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 18;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_R_W  = 17;
  localparam int unsigned DVD_W    = 18;
  localparam int unsigned CNT_W    = 5;

  localparam logic [ANG_W-1:0]   ANG_MAX  = 17'h1FFFF;
  localparam logic [ANG_W-1:0]   Q16_ONE  = 17'h10000;
  localparam logic [MUL_B_W-1:0] EASE_K   = 18'd196608;
  localparam logic [CNT_W-1:0]   LEN_STEPS = 5'd18;
  localparam logic [CNT_W-1:0]   U_STEPS   = 5'd16;

  localparam logic [1:0] CFG_STEP   = 2'd0;
  localparam logic [1:0] CFG_BLEND  = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CHK   = 11'b000_0000_0010,
    ST_DLEN  = 11'b000_0000_0100,
    ST_TICK  = 11'b000_0000_1000,
    ST_DIVU  = 11'b000_0001_0000,
    ST_MSQ   = 11'b000_0010_0000,
    ST_MEASE = 11'b000_0100_0000,
    ST_MBL   = 11'b000_1000_0000,
    ST_MGO   = 11'b001_0000_0000,
    ST_MSPAN = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_R_W-1:0] rem;
    logic [DVD_W-1:0]   dvd;
    logic [DIV_R_W-1:0] divisor;
    logic [CNT_W-1:0]   steps;
  } div_req_t;

endpackage

@@ hdl/sjmp_sermul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on sjmp_pkg.
module sjmp_sermul import sjmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0] p_q, p_d;
  logic [MUL_A_W-1:0] a_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [MUL_A_W:0]   sum;

  always_comb begin
    sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {sum, p_q[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !req_i.start;
      if (req_i.start) begin
        cnt_q <= CNT_W'(MUL_B_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // operand and product need no reset
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{MUL_A_W{1'b0}}, req_i.b};
    end else if (cnt_q != '0) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hdl/sjmp_serdiv.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on sjmp_pkg.
module sjmp_serdiv import sjmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  logic [DIV_R_W-1:0] rem_q, divisor_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [DIV_R_W:0]   r2, r2_sub;
  logic               ge;

  always_comb begin
    r2     = {rem_q, dvd_q[DVD_W-1]};
    r2_sub = r2 - {1'b0, divisor_q};
    ge     = r2 >= {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1)) && !req_i.start;
      if (req_i.start) begin
        cnt_q <= req_i.steps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.rem;
      dvd_q     <= req_i.dvd;
      divisor_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? r2_sub[DIV_R_W-1:0] : r2[DIV_R_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ hdl/synced_joint_motion_profiler.sv @@
// Top level of the synced joint motion profiler: control sequencer and joint state.
// Depends on sjmp_pkg, sjmp_sermul, sjmp_serdiv and the defines header.
//
//  channel  | direction | tdata (low bit up)               | tuser
//  s_axis   | in        | shoulder,elbow,wrist,twist,claw  | cmd
//  m_axis   | out       | five setpoints, same order        | moving
//  cfg      | in        | index 0..2, 16 bit data           | -
//
// An idle tick or the last tick of a move goes from ST_TICK straight to ST_OUT; a snap passes ST_CHK first.
// A new move adds the length division in ST_DLEN; any other tick of a move runs
// the divider for u and then 8 serial products (square, ease, blend, five joint spans)
// through ST_DIVU, ST_MSQ, ST_MEASE, ST_MBL and ST_MGO/ST_MSPAN.
// Reset puts every joint at its home angle with no move running.
// A stalled result holds in the output register; the next item runs and waits in ST_OUT.
module synced_joint_motion_profiler import sjmp_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // shoulder,elbow,wrist,twist,claw targets
  input  logic [0:0]         s_axis_tuser,  // cmd
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // shoulder,elbow,wrist,twist,claw setpoints
  output logic [0:0]         m_axis_tuser,  // moving
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  `include "synced_joint_motion_profiler_defines.svh"

  // home angles, cut to the angle width
  localparam logic [ANG_W-1:0] HOME_90  = ANG_W'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0] HOME_180 = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic [NJ-1:0][ANG_W-1:0] HOME = {HOME_90, HOME_90, HOME_90, HOME_180, HOME_90};

  state_e state_q, state_d;

  logic [NJ-1:0][ANG_W-1:0] tgt_q;
  logic                     cmd_q;
  logic [NJ-1:0][ANG_W-1:0] goal_q, goal_d, start_q, start_d, cur_q, cur_d;
  logic [ANG_W-1:0]         tick_q, tick_d, len_q, len_d;
  logic [15:0]              u_q, u_d;
  logic [ANG_W-1:0]         eased_q, eased_d, s_q, s_d;
  logic [2:0]               jidx_q, jidx_d;

  logic [15:0]              step_q, blend_q;
  logic [7:0]               thr_q;

  logic                     m_valid_q;
  logic [TDATA_W-1:0]       m_data_q;
  logic                     m_user_q;

  mul_req_t                 mul_req;
  logic                     mul_done;
  logic [MUL_P_W-1:0]       mul_prod;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quot;

  logic                     in_acc, out_load;

  sjmp_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  sjmp_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    logic [ANG_W-1:0]   maxd, dj, tick_inc, eased_w, term, span_mag;
    logic [15:0]        step_eff;
    logic [ANG_W:0]     diff_w;
    logic [DVD_W:0]     s_raw, v_raw;
    logic               diff_neg, span_neg;
    logic [MUL_P_W-1:0] rnd;

    state_d = state_q;
    goal_d  = goal_q;
    start_d = start_q;
    cur_d   = cur_q;
    tick_d  = tick_q;
    len_d   = len_q;
    u_d     = u_q;
    eased_d = eased_q;
    s_d     = s_q;
    jidx_d  = jidx_q;
    mul_req = '0;
    div_req = '0;

    step_eff = (step_q == '0) ? 16'd1 : step_q;

    // largest joint distance between targets and present setpoints
    maxd = '0;
    for (int j = 0; j < NJ; j++) begin
      dj = (tgt_q[j] >= cur_q[j]) ? tgt_q[j] - cur_q[j] : cur_q[j] - tgt_q[j];
      if (dj > maxd) maxd = dj;
    end

    tick_inc = tick_q + ANG_W'(1);

    diff_w   = {2'b00, u_q} - {1'b0, eased_q};
    diff_neg = diff_w[ANG_W];

    span_neg = goal_q[jidx_q] < start_q[jidx_q];
    span_mag = span_neg ? start_q[jidx_q] - goal_q[jidx_q]
                        : goal_q[jidx_q] - start_q[jidx_q];

    eased_w = '0;
    term    = '0;
    s_raw   = '0;
    v_raw   = '0;
    rnd     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = s_axis_tuser[0] ? ST_CHK : ST_TICK;
      end
      ST_CHK: begin
        goal_d = tgt_q;
        tick_d = '0;
        if (maxd < {{(ANG_W-8){1'b0}}, thr_q}) begin
          // snap: no move
          cur_d   = tgt_q;
          len_d   = '0;
          state_d = ST_TICK;
        end else begin
          start_d         = cur_q;
          div_req.start   = 1'b1;
          div_req.rem     = '0;
          div_req.dvd     = {1'b0, maxd} + {2'b00, step_eff} - DVD_W'(1);
          div_req.divisor = {1'b0, step_eff};
          div_req.steps   = LEN_STEPS;
          state_d         = ST_DLEN;
        end
      end
      ST_DLEN: begin
        if (div_done) begin
          len_d   = (div_quot == '0) ? ANG_W'(1) : div_quot[ANG_W-1:0];
          state_d = ST_TICK;
        end
      end
      ST_TICK: begin
        if (tick_q < len_q) begin
          tick_d = tick_inc;
          if (tick_inc >= len_q) begin
            cur_d   = goal_q;
            state_d = ST_OUT;
          end else begin
            // u = tick * 2^16 / length
            div_req.start   = 1'b1;
            div_req.rem     = tick_inc;
            div_req.dvd     = '0;
            div_req.divisor = len_q;
            div_req.steps   = U_STEPS;
            state_d         = ST_DIVU;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIVU: begin
        if (div_done) begin
          u_d           = div_quot[15:0];
          mul_req.start = 1'b1;
          mul_req.a     = {16'd0, div_quot[15:0]};
          mul_req.b     = {2'b00, div_quot[15:0]};
          state_d       = ST_MSQ;
        end
      end
      ST_MSQ: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_prod[MUL_A_W-1:0];
          mul_req.b     = EASE_K - {1'b0, u_q, 1'b0};
          state_d       = ST_MEASE;
        end
      end
      ST_MEASE: begin
        if (mul_done) begin
          rnd      = mul_prod + (MUL_P_W'(1) << 31);
          eased_w  = rnd[48:32];
          eased_d  = eased_w;
          diff_w   = {2'b00, u_q} - {1'b0, eased_w};
          diff_neg = diff_w[ANG_W];
          mul_req.start = 1'b1;
          mul_req.a = MUL_A_W'(diff_neg ? ANG_W'(-diff_w) : diff_w[ANG_W-1:0]);
          mul_req.b = {2'b00, blend_q};
          state_d   = ST_MBL;
        end
      end
      ST_MBL: begin
        if (mul_done) begin
          rnd   = mul_prod + (MUL_P_W'(1) << 15);
          term  = rnd[32:16];
          s_raw = diff_neg ? {2'b00, eased_q} - {2'b00, term}
                           : {2'b00, eased_q} + {2'b00, term};
          // clamp s to [0, 1.0]
          if (s_raw[DVD_W]) s_d = '0;
          else if (s_raw[DVD_W-1:0] > {1'b0, Q16_ONE}) s_d = Q16_ONE;
          else s_d = s_raw[ANG_W-1:0];
          jidx_d  = '0;
          state_d = ST_MGO;
        end
      end
      ST_MGO: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(span_mag);
        mul_req.b     = {1'b0, s_q};
        state_d       = ST_MSPAN;
      end
      ST_MSPAN: begin
        if (mul_done) begin
          rnd   = mul_prod + (MUL_P_W'(1) << 15);
          term  = rnd[32:16];
          v_raw = span_neg ? {2'b00, start_q[jidx_q]} - {2'b00, term}
                           : {2'b00, start_q[jidx_q]} + {2'b00, term};
          if (v_raw[DVD_W]) cur_d[jidx_q] = '0;
          else if (v_raw[DVD_W-1]) cur_d[jidx_q] = ANG_MAX;
          else cur_d[jidx_q] = v_raw[ANG_W-1:0];
          if (jidx_q == 3'(NJ - 1)) begin
            state_d = ST_OUT;
          end else begin
            jidx_d  = jidx_q + 3'd1;
            state_d = ST_MGO;
          end
        end
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      goal_q    <= HOME;
      start_q   <= HOME;
      cur_q     <= HOME;
      tick_q    <= '0;
      len_q     <= '0;
      jidx_q    <= '0;
      step_q    <= 16'd72;
      blend_q   <= 16'd22938;
      thr_q     <= 8'd1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      goal_q  <= goal_d;
      start_q <= start_d;
      cur_q   <= cur_d;
      tick_q  <= tick_d;
      len_q   <= len_d;
      jidx_q  <= jidx_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_STEP:   step_q  <= cfg_data_i;
          CFG_BLEND:  blend_q <= cfg_data_i;
          CFG_THRESH: thr_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    eased_q <= eased_d;
    s_q     <= s_d;
    if (in_acc) begin
      cmd_q <= s_axis_tuser[0];
      for (int j = 0; j < NJ; j++) tgt_q[j] <= s_axis_tdata[j*ANG_W +: ANG_W];
    end
    if (out_load) begin
      m_data_q <= {{(TDATA_W - NJ*ANG_W){1'b0}}, cur_q};
      m_user_q <= tick_q < len_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  `SJMP_ASSERT_IMPL(a_tick_in_range, 1'b1, tick_q <= len_q, "tick count past move length")
  `SJMP_ASSERT_IMPL(a_settled_on_goal, (state_q == ST_IDLE) && (tick_q == len_q) && !cmd_q, cur_q == goal_q, "idle with no move but setpoints off goal")
  `SJMP_ASSERT_IMPL(a_result_from_out, $rose(m_axis_tvalid), $past(state_q == ST_OUT), "result raised outside output state")

endmodule
